// File: hdl/tgrf_pkg.sv
// tgrf_pkg: shared types, codes and default constants of the tile grid rectangle fill block
// no dependencies; used by tgrf_ctrl, tgrf_datapath and tile_grid_rect_fill

package tgrf_pkg;

	localparam int MAX_COLS_DEF  = 64;
	localparam int MAX_ROWS_DEF  = 64;
	localparam int TILE_BITS_DEF = 32;

	localparam logic [31:0] NARROW_MAX = 32'h0000_FFFF;

	localparam int CFG_IDX_W = 2;
	localparam int CELLS_W   = 14;
	localparam int COORD_W   = 7;

	typedef enum logic [1:0] {
		OP_READ      = 2'd0,
		OP_FILL_RECT = 2'd1,
		OP_FILL_GRID = 2'd2
	} op_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_COLS    = 2'd0,
		CFG_GRID_ROWS    = 2'd1,
		CFG_WIDE_MODE    = 2'd2,
		CFG_DEFAULT_TILE = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_WRITTEN  = 3'd0,
		ST_NOOP     = 3'd1,
		ST_READ_OK  = 3'd2,
		ST_READ_OUT = 3'd3,
		ST_COUNTED  = 3'd4
	} status_code_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
		logic [31:0]        tile_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] read_value;
		logic [12:0] resident_cells;
		logic [31:0] mutation_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic calc;
		logic flood_step;
		logic fill_step;
		logic rd_issue;
		logic finish;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_go;
		logic need_flood;
		logic narrow_skip;
		logic rd_mem;
		logic flood_last;
		logic fill_last;
		logic out_free;
	} dp_status_t;

endpackage

// File: hdl/tgrf_ctrl.sv
// tgrf_ctrl: request sequencer of the tile grid rectangle fill block
// depends on tgrf_pkg; drives the datapath through dp_cmd_t and reads dp_status_t

module tgrf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   cfg_ready,
	input  tgrf_pkg::dp_status_t   st,
	output tgrf_pkg::dp_cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b000_0001,
		S_CALC  = 7'b000_0010,
		S_DISP  = 7'b000_0100,
		S_FLOOD = 7'b000_1000,
		S_FILL  = 7'b001_0000,
		S_RDMEM = 7'b010_0000,
		S_DONE  = 7'b100_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_DISP;
			end
			S_DISP: begin
				if (st.fill_go) begin
					if (st.need_flood) begin
						state_d = S_FLOOD;
					end else if (st.narrow_skip) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FILL;
					end
				end else if (st.rd_mem) begin
					state_d = S_RDMEM;
				end else begin
					state_d = S_DONE;
				end
			end
			S_FLOOD: begin
				cmd.flood_step = 1'b1;
				if (st.flood_last) begin
					state_d = st.narrow_skip ? S_DONE : S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (st.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_RDMEM: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				cmd.finish = st.out_free;
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;

`ifndef SYNTH
	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_CALC))
		else $error("accepted request not followed by calc");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("result written over a pending result");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.flood_step && cmd.fill_step))
		else $error("flood and fill in the same cycle");
`endif

endmodule

// File: hdl/tgrf_datapath.sv
// tgrf_datapath: configuration registers, rectangle clipping, tile store and result register
// depends on tgrf_pkg; sequenced by tgrf_ctrl

module tgrf_datapath #(
	parameter int MAX_COLS  = tgrf_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS  = tgrf_pkg::MAX_ROWS_DEF,
	parameter int TILE_BITS = tgrf_pkg::TILE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tgrf_pkg::req_t                    in_data,
	input  logic                              cfg_we,
	input  logic [tgrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              out_stall,
	output logic                              out_valid,
	output tgrf_pkg::rsp_t                    out_data,
	input  tgrf_pkg::dp_cmd_t                 cmd,
	output tgrf_pkg::dp_status_t              st
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = (IDX_W > 15) ? IDX_W : 15;
	localparam int CW    = tgrf_pkg::COORD_W;
	localparam int NW    = tgrf_pkg::CELLS_W;

	// configuration
	logic [CW-1:0]  grid_cols_q;
	logic [CW-1:0]  grid_rows_q;
	logic           wide_q;
	logic [31:0]    default_q;

	// persistent state
	logic [NW-1:0]  filled_size_q;
	logic           filled_wide_q;
	logic [NW-1:0]  resident_q;
	logic [31:0]    mut_q;

	// request in flight
	tgrf_pkg::req_t req_q;
	tgrf_pkg::status_code_t code_q;
	logic                   fill_go_q;
	logic                   need_flood_q;
	logic                   skip_q;
	logic                   rd_mem_q;
	logic                   read_in_q;
	logic [NW-1:0]          cells_q;
	logic [CW-1:0]          cols_q;
	logic [TILE_BITS-1:0]   flood_val_q;
	logic [TILE_BITS-1:0]   id_q;
	logic [CW-1:0]          x0_q;
	logic [CW-1:0]          x1m1_q;
	logic [CW-1:0]          y1m1_q;
	logic [CW-1:0]          col_q;
	logic [CW-1:0]          row_q;
	logic [IDX_W-1:0]       addr_q;
	logic [IDX_W-1:0]       row_start_q;
	logic [IDX_W-1:0]       fl_q;
	logic [TILE_BITS-1:0]   rd_q;

	logic [TILE_BITS-1:0]   tile_store_q [DEPTH];

	logic                   out_valid_q;
	tgrf_pkg::rsp_t         out_q;

	// clipping and classification
	logic [CW-1:0]          cols;
	logic [CW-1:0]          rows;
	logic [NW-1:0]          cells;
	logic signed [15:0]     cols_s;
	logic signed [15:0]     rows_s;
	logic signed [15:0]     x0;
	logic signed [15:0]     y0;
	logic signed [15:0]     x1;
	logic signed [15:0]     y1;
	logic signed [15:0]     x1c;
	logic signed [15:0]     y1c;
	logic                   grid_empty;
	logic                   is_read;
	logic                   is_fill;
	logic                   fill_go;
	logic                   read_in;
	logic                   flooded;
	logic                   narrow_skip;
	logic [TILE_BITS-1:0]   flood_val;
	logic [CW-1:0]          sel_x;
	logic [CW-1:0]          sel_y;
	logic [NW-1:0]          prod;
	logic [SUM_W-1:0]       base_sum;
	logic [SUM_W-1:0]       next_row_sum;
	tgrf_pkg::status_code_t code;

	always_comb begin
		cols = (int'(grid_cols_q) > MAX_COLS) ? CW'(MAX_COLS) : grid_cols_q;
		rows = (int'(grid_rows_q) > MAX_ROWS) ? CW'(MAX_ROWS) : grid_rows_q;
		cells = {{(NW-CW){1'b0}}, cols} * {{(NW-CW){1'b0}}, rows};
		cols_s = $signed({{(16-CW){1'b0}}, cols});
		rows_s = $signed({{(16-CW){1'b0}}, rows});
		grid_empty = (cols == '0) || (rows == '0);
		is_read = (req_q.operation == tgrf_pkg::OP_READ);
		is_fill = (req_q.operation == tgrf_pkg::OP_FILL_RECT)
			|| (req_q.operation == tgrf_pkg::OP_FILL_GRID);

		if (req_q.operation == tgrf_pkg::OP_FILL_GRID) begin
			x0 = '0;
			y0 = '0;
			x1 = cols_s;
			y1 = rows_s;
		end else begin
			x0 = req_q.rect_left;
			y0 = req_q.rect_top;
			x1 = req_q.rect_right;
			y1 = req_q.rect_bottom;
		end
		x1c = (x1 > cols_s) ? cols_s : x1;
		y1c = (y1 > rows_s) ? rows_s : y1;

		fill_go = is_fill && !grid_empty && (x1 > x0) && (y1 > y0)
			&& (x0 >= 16'sd0) && (y0 >= 16'sd0) && (x1c > x0) && (y1c > y0);
		read_in = is_read && (req_q.rect_left >= 16'sd0) && (req_q.rect_top >= 16'sd0)
			&& (req_q.rect_left < cols_s) && (req_q.rect_top < rows_s);

		flooded = (filled_size_q != '0) && (filled_size_q == cells)
			&& (filled_wide_q == wide_q);
		narrow_skip = !wide_q && (req_q.tile_value > tgrf_pkg::NARROW_MAX);

		if (wide_q) begin
			flood_val = default_q[TILE_BITS-1:0];
		end else if (default_q > tgrf_pkg::NARROW_MAX) begin
			flood_val = '0;
		end else begin
			flood_val = TILE_BITS'(default_q[15:0]);
		end

		sel_x = is_read ? req_q.rect_left[CW-1:0] : x0[CW-1:0];
		sel_y = is_read ? req_q.rect_top[CW-1:0] : y0[CW-1:0];
		prod = {{(NW-CW){1'b0}}, sel_y} * {{(NW-CW){1'b0}}, cols};
		base_sum = SUM_W'(prod) + SUM_W'(sel_x);

		if (is_read) begin
			code = read_in ? tgrf_pkg::ST_READ_OK : tgrf_pkg::ST_READ_OUT;
		end else if (fill_go) begin
			code = narrow_skip ? tgrf_pkg::ST_COUNTED : tgrf_pkg::ST_WRITTEN;
		end else begin
			code = tgrf_pkg::ST_NOOP;
		end
	end

	assign next_row_sum = SUM_W'(row_start_q) + SUM_W'(cols_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= '0;
			grid_rows_q <= '0;
			wide_q      <= 1'b1;
			default_q   <= '0;
		end else if (cfg_we) begin
			case (tgrf_pkg::cfg_reg_t'(cfg_index))
				tgrf_pkg::CFG_GRID_COLS:    grid_cols_q <= cfg_data[CW-1:0];
				tgrf_pkg::CFG_GRID_ROWS:    grid_rows_q <= cfg_data[CW-1:0];
				tgrf_pkg::CFG_WIDE_MODE:    wide_q      <= cfg_data[0];
				tgrf_pkg::CFG_DEFAULT_TILE: default_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// flood bookkeeping and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_size_q <= '0;
			filled_wide_q <= 1'b0;
			resident_q    <= '0;
			mut_q         <= '0;
		end else if (cmd.calc && fill_go) begin
			mut_q <= mut_q + 32'd1;
			if (!flooded) begin
				filled_size_q <= cells;
				filled_wide_q <= wide_q;
				resident_q    <= cells;
			end
		end
	end

	// request registers and walk counters
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.calc) begin
			code_q       <= code;
			fill_go_q    <= fill_go;
			need_flood_q <= fill_go && !flooded;
			skip_q       <= narrow_skip;
			rd_mem_q     <= read_in && flooded;
			read_in_q    <= read_in;
			cells_q      <= cells;
			cols_q       <= cols;
			flood_val_q  <= flood_val;
			id_q         <= req_q.tile_value[TILE_BITS-1:0];
			x0_q         <= x0[CW-1:0];
			x1m1_q       <= x1c[CW-1:0] - CW'(1);
			y1m1_q       <= y1c[CW-1:0] - CW'(1);
			col_q        <= x0[CW-1:0];
			row_q        <= y0[CW-1:0];
			addr_q       <= base_sum[IDX_W-1:0];
			row_start_q  <= base_sum[IDX_W-1:0];
			fl_q         <= '0;
		end
		if (cmd.flood_step) begin
			fl_q <= fl_q + IDX_W'(1);
		end
		if (cmd.fill_step) begin
			if (col_q == x1m1_q) begin
				col_q       <= x0_q;
				row_q       <= row_q + CW'(1);
				row_start_q <= next_row_sum[IDX_W-1:0];
				addr_q      <= next_row_sum[IDX_W-1:0];
			end else begin
				col_q  <= col_q + CW'(1);
				addr_q <= addr_q + IDX_W'(1);
			end
		end
	end

	// tile store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.flood_step) begin
			tile_store_q[fl_q] <= flood_val_q;
		end else if (cmd.fill_step) begin
			tile_store_q[addr_q] <= id_q;
		end
		if (cmd.rd_issue) begin
			rd_q <= tile_store_q[addr_q];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status         <= code_q;
			out_q.resident_cells <= resident_q[12:0];
			out_q.mutation_count <= mut_q;
			if (!read_in_q) begin
				out_q.read_value <= '0;
			end else if (rd_mem_q) begin
				out_q.read_value <= 32'(rd_q);
			end else begin
				out_q.read_value <= 32'(flood_val_q);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		st.fill_go     = fill_go_q;
		st.need_flood  = need_flood_q;
		st.narrow_skip = skip_q;
		st.rd_mem      = rd_mem_q;
		st.flood_last  = (SUM_W'(fl_q) == (SUM_W'(cells_q) - SUM_W'(1)));
		st.fill_last   = (col_q == x1m1_q) && (row_q == y1m1_q);
		st.out_free    = !out_valid_q || !out_stall;
	end

`ifndef SYNTH
	a_fill_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> (SUM_W'(addr_q) < SUM_W'(cells_q)))
		else $error("fill address beyond the grid");

	a_flood_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flood_step |-> (SUM_W'(fl_q) < SUM_W'(cells_q)))
		else $error("flood address beyond the grid");

	a_flood_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.calc && fill_go) |=> (filled_size_q != '0))
		else $error("fill left the store unmarked");
`endif

endmodule

// File: hdl/tile_grid_rect_fill.sv
// tile_grid_rect_fill: top level of the clipped rectangle fill block over a tile-id store
// depends on tgrf_pkg, tgrf_ctrl and tgrf_datapath
//
// usage
//   in_valid / in_stall / in_data carry one request (read cell, fill rectangle, fill grid);
//   a request is taken at a clock edge with in_valid high and in_stall low.
//   out_valid / out_stall / out_data return exactly one result per request, in order.
//   cfg_valid / cfg_ready / cfg_index / cfg_data write the four configuration registers;
//   cfg_ready is high only while the block is idle and no request is offered.
// sequence
//   clipping and dispatch each have a state; then a read of a written cell reads the store,
//   a fill writes its clipped cells one by one, after a flood of every grid cell when the
//   store is not yet flooded for the current size and mode, a narrow-mode fill of a value
//   too wide for it writes no cells (only any flood), and the result load comes last; the
//   single store write port sets the one-cell-per-cycle rate. the next request is taken
//   only once the block is back in idle after the result load, so requests never overlap.
// reset and stall
//   reset restores the register defaults (wide mode on) and marks the store unflooded;
//   the store needs no clearing. a stalled result holds in the output register while the
//   next request is taken and worked on; only its result load waits for the register.

module tile_grid_rect_fill #(
	parameter int MAX_COLS  = tgrf_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS  = tgrf_pkg::MAX_ROWS_DEF,
	parameter int TILE_BITS = tgrf_pkg::TILE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tgrf_pkg::req_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tgrf_pkg::rsp_t                  out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tgrf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_data
);

	tgrf_pkg::dp_cmd_t    cmd;
	tgrf_pkg::dp_status_t st;

	tgrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	tgrf_datapath #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.TILE_BITS (TILE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
